[rtl/llm_pkg.sv]
// Shared constants, types and helpers for the linked list manager.
// Used by the channel interfaces, the controller and the datapath.
package llm_pkg;

  localparam int unsigned NODES  = 16;
  localparam int unsigned VAL_W  = 32;
  localparam int unsigned IDX_W  = $clog2(NODES);
  localparam int unsigned HDL_W  = $clog2(NODES + 1);
  localparam int unsigned ACT_W  = 3;
  localparam int unsigned STAT_W = 2;

  typedef logic [HDL_W-1:0] handle_t;
  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [VAL_W-1:0] value_t;

  localparam handle_t HANDLE_NONE = HDL_W'(NODES);

  typedef enum logic [ACT_W-1:0] {
    ACT_PREPEND = 3'd0,
    ACT_APPEND  = 3'd1,
    ACT_INSERT  = 3'd2,
    ACT_RM_HEAD = 3'd3,
    ACT_RM_VAL  = 3'd4,
    ACT_FIND    = 3'd5,
    ACT_CLEAR   = 3'd6
  } action_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_MISS  = 2'd1,
    ST_FULL  = 2'd2,
    ST_STALE = 2'd3
  } status_e;

  typedef enum logic [4:0] {
    DP_NOP,
    DP_LOAD,
    DP_PREPEND,
    DP_APPEND,
    DP_APPEND_LINK,
    DP_INS_CLAIM,
    DP_INS_LINK,
    DP_INS_AFTER,
    DP_RMH_READ,
    DP_RMH_TAKE,
    DP_WALK_START,
    DP_WALK_NEXT,
    DP_FOUND,
    DP_UNLINK,
    DP_SET_MISS,
    DP_SET_FULL,
    DP_SET_STALE,
    DP_CLEAR,
    DP_EMIT
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic [ACT_W-1:0] act;
    logic             after_live;
    logic             pool_full;
    logic             head_live;
    logic             match;
    logic             next_live;
    logic             out_busy;
  } dp_stat_t;

  function automatic logic is_live(logic [NODES-1:0] use_v, handle_t h);
    logic r;
    r = 1'b0;
    if (h < HANDLE_NONE) begin
      r = use_v[h[IDX_W-1:0]];
    end
    return r;
  endfunction

  function automatic handle_t lowest_free(logic [NODES-1:0] use_v);
    handle_t r;
    r = HANDLE_NONE;
    for (int i = int'(NODES) - 1; i >= 0; i--) begin
      if (!use_v[i]) begin
        r = HDL_W'(i);
      end
    end
    return r;
  endfunction

endpackage

[rtl/llm_req_if.sv]
// Request channel of the linked list manager: valid/ready plus one action beat.
// Depends on llm_pkg.
interface llm_req_if;
  import llm_pkg::*;

  logic             valid;
  logic             ready;
  logic [ACT_W-1:0] action;
  value_t           item_value;
  idx_t             after_node;

  modport source(output valid, output action, output item_value, output after_node,
                 input ready);
  modport sink(input valid, input action, input item_value, input after_node,
               output ready);
endinterface

[rtl/llm_rsp_if.sv]
// Response channel of the linked list manager: valid/ready plus one result beat.
// Depends on llm_pkg.
interface llm_rsp_if;
  import llm_pkg::*;

  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  handle_t           node_handle;
  value_t            removed_value;
  handle_t           list_length;
  handle_t           first_node;
  handle_t           last_node;

  modport source(output valid, output status, output node_handle, output removed_value,
                 output list_length, output first_node, output last_node,
                 input ready);
  modport sink(input valid, input status, input node_handle, input removed_value,
               input list_length, input first_node, input last_node,
               output ready);
endinterface

[rtl/llm_ctrl.sv]
// Controller state machine of the linked list manager.
// Sequences datapath commands per action; depends on llm_pkg.
module llm_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             req_valid_i,
  output logic             req_ready_o,
  input  llm_pkg::dp_stat_t stat_i,
  output llm_pkg::dp_cmd_t  cmd_o
);
  import llm_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_DISP = 8'b0000_0010,
    S_APP2 = 8'b0000_0100,
    S_INS2 = 8'b0000_1000,
    S_INS3 = 8'b0001_0000,
    S_RMH  = 8'b0010_0000,
    S_WALK = 8'b0100_0000,
    S_DONE = 8'b1000_0000
  } ctrl_state_e;

  ctrl_state_e state_q, state_d;

  assign req_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d   = state_q;
    cmd_o.op  = DP_NOP;
    case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          cmd_o.op = DP_LOAD;
          state_d  = S_DISP;
        end
      end
      S_DISP: begin
        state_d = S_DONE;
        case (stat_i.act)
          ACT_PREPEND: begin
            cmd_o.op = stat_i.pool_full ? DP_SET_FULL : DP_PREPEND;
          end
          ACT_APPEND: begin
            if (stat_i.pool_full) begin
              cmd_o.op = DP_SET_FULL;
            end else begin
              cmd_o.op = DP_APPEND;
              state_d  = S_APP2;
            end
          end
          ACT_INSERT: begin
            if (!stat_i.after_live) begin
              cmd_o.op = DP_SET_STALE;
            end else if (stat_i.pool_full) begin
              cmd_o.op = DP_SET_FULL;
            end else begin
              cmd_o.op = DP_INS_CLAIM;
              state_d  = S_INS2;
            end
          end
          ACT_RM_HEAD: begin
            if (!stat_i.head_live) begin
              cmd_o.op = DP_SET_MISS;
            end else begin
              cmd_o.op = DP_RMH_READ;
              state_d  = S_RMH;
            end
          end
          ACT_RM_VAL, ACT_FIND: begin
            if (!stat_i.head_live) begin
              cmd_o.op = DP_SET_MISS;
            end else begin
              cmd_o.op = DP_WALK_START;
              state_d  = S_WALK;
            end
          end
          ACT_CLEAR: begin
            cmd_o.op = DP_CLEAR;
          end
          default: begin
            cmd_o.op = DP_NOP;
          end
        endcase
      end
      S_APP2: begin
        cmd_o.op = DP_APPEND_LINK;
        state_d  = S_DONE;
      end
      S_INS2: begin
        cmd_o.op = DP_INS_LINK;
        state_d  = S_INS3;
      end
      S_INS3: begin
        cmd_o.op = DP_INS_AFTER;
        state_d  = S_DONE;
      end
      S_RMH: begin
        cmd_o.op = DP_RMH_TAKE;
        state_d  = S_DONE;
      end
      S_WALK: begin
        if (stat_i.match) begin
          cmd_o.op = (stat_i.act == ACT_FIND) ? DP_FOUND : DP_UNLINK;
          state_d  = S_DONE;
        end else if (stat_i.next_live) begin
          cmd_o.op = DP_WALK_NEXT;
        end else begin
          cmd_o.op = DP_SET_MISS;
          state_d  = S_DONE;
        end
      end
      S_DONE: begin
        if (!stat_i.out_busy) begin
          cmd_o.op = DP_EMIT;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[rtl/llm_dpath.sv]
// Datapath of the linked list manager: node value and link memories,
// head/tail/count registers, in-use bits and the result register. Depends on llm_pkg.
module llm_dpath (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  llm_pkg::dp_cmd_t          cmd_i,
  output llm_pkg::dp_stat_t         stat_o,
  input  logic [llm_pkg::ACT_W-1:0] action_i,
  input  llm_pkg::value_t           item_value_i,
  input  llm_pkg::idx_t             after_node_i,
  output logic                      rsp_valid_o,
  input  logic                      rsp_ready_i,
  output logic [llm_pkg::STAT_W-1:0] status_o,
  output llm_pkg::handle_t          node_handle_o,
  output llm_pkg::value_t           removed_value_o,
  output llm_pkg::handle_t          list_length_o,
  output llm_pkg::handle_t          first_node_o,
  output llm_pkg::handle_t          last_node_o
);
  import llm_pkg::*;

  value_t  val_mem  [NODES];
  handle_t link_mem [NODES];
  value_t  val_rd_q;
  handle_t link_rd_q;

  logic [NODES-1:0] in_use_q;
  handle_t          head_q, tail_q, count_q;
  logic             out_valid_q;

  logic [ACT_W-1:0]  act_q;
  value_t            val_q;
  idx_t              after_q;
  handle_t           cur_q, prev_q;
  logic [STAT_W-1:0] res_status_q;
  handle_t           res_handle_q;
  value_t            res_removed_q;

  logic [STAT_W-1:0] out_status_q;
  handle_t           out_handle_q, out_length_q, out_first_q, out_last_q;
  value_t            out_removed_q;

  handle_t slot;
  idx_t    slot_idx;
  handle_t after_h;

  logic    val_we, link_we, rd_en;
  idx_t    val_waddr, link_waddr, rd_addr;
  value_t  val_wdata;
  handle_t link_wdata;

  assign slot     = lowest_free(in_use_q);
  assign slot_idx = slot[IDX_W-1:0];
  assign after_h  = HDL_W'(after_q);

  assign stat_o.act        = act_q;
  assign stat_o.after_live = is_live(in_use_q, after_h);
  assign stat_o.pool_full  = &in_use_q;
  assign stat_o.head_live  = is_live(in_use_q, head_q);
  assign stat_o.match      = (val_rd_q == val_q);
  assign stat_o.next_live  = is_live(in_use_q, link_rd_q);
  assign stat_o.out_busy   = out_valid_q && !rsp_ready_i;

  always_comb begin
    val_we     = 1'b0;
    val_waddr  = slot_idx;
    val_wdata  = val_q;
    link_we    = 1'b0;
    link_waddr = slot_idx;
    link_wdata = HANDLE_NONE;
    rd_en      = 1'b0;
    rd_addr    = head_q[IDX_W-1:0];
    case (cmd_i.op)
      DP_PREPEND: begin
        val_we     = 1'b1;
        link_we    = 1'b1;
        link_wdata = head_q;
      end
      DP_APPEND: begin
        val_we  = 1'b1;
        link_we = 1'b1;
      end
      DP_APPEND_LINK: begin
        link_we    = is_live(in_use_q, prev_q);
        link_waddr = prev_q[IDX_W-1:0];
        link_wdata = cur_q;
      end
      DP_INS_CLAIM: begin
        val_we  = 1'b1;
        rd_en   = 1'b1;
        rd_addr = after_q;
      end
      DP_INS_LINK: begin
        link_we    = 1'b1;
        link_waddr = cur_q[IDX_W-1:0];
        link_wdata = link_rd_q;
      end
      DP_INS_AFTER: begin
        link_we    = 1'b1;
        link_waddr = after_q;
        link_wdata = cur_q;
      end
      DP_RMH_READ, DP_WALK_START: begin
        rd_en = 1'b1;
      end
      DP_WALK_NEXT: begin
        rd_en   = 1'b1;
        rd_addr = link_rd_q[IDX_W-1:0];
      end
      DP_UNLINK: begin
        link_we    = (prev_q != HANDLE_NONE);
        link_waddr = prev_q[IDX_W-1:0];
        link_wdata = link_rd_q;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (val_we) begin
      val_mem[val_waddr] <= val_wdata;
    end
    if (link_we) begin
      link_mem[link_waddr] <= link_wdata;
    end
    if (rd_en) begin
      val_rd_q  <= val_mem[rd_addr];
      link_rd_q <= link_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_use_q    <= '0;
      head_q      <= HANDLE_NONE;
      tail_q      <= HANDLE_NONE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.op == DP_EMIT) begin
        out_valid_q <= 1'b1;
      end else if (rsp_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (cmd_i.op)
        DP_PREPEND: begin
          in_use_q[slot_idx] <= 1'b1;
          head_q             <= slot;
          if (tail_q == HANDLE_NONE) begin
            tail_q <= slot;
          end
          count_q <= count_q + HDL_W'(1);
        end
        DP_APPEND: begin
          in_use_q[slot_idx] <= 1'b1;
          if (!is_live(in_use_q, tail_q)) begin
            head_q <= slot;
          end
          tail_q  <= slot;
          count_q <= count_q + HDL_W'(1);
        end
        DP_INS_CLAIM: begin
          in_use_q[slot_idx] <= 1'b1;
          count_q            <= count_q + HDL_W'(1);
        end
        DP_INS_LINK: begin
          if (tail_q == after_h) begin
            tail_q <= cur_q;
          end
        end
        DP_RMH_TAKE: begin
          head_q <= link_rd_q;
          if (link_rd_q == HANDLE_NONE) begin
            tail_q <= HANDLE_NONE;
          end
          in_use_q[cur_q[IDX_W-1:0]] <= 1'b0;
          if (count_q != '0) begin
            count_q <= count_q - HDL_W'(1);
          end
        end
        DP_UNLINK: begin
          if (prev_q == HANDLE_NONE) begin
            head_q <= link_rd_q;
          end
          if (tail_q == cur_q) begin
            tail_q <= prev_q;
          end
          in_use_q[cur_q[IDX_W-1:0]] <= 1'b0;
          if (count_q != '0) begin
            count_q <= count_q - HDL_W'(1);
          end
        end
        DP_CLEAR: begin
          in_use_q <= '0;
          head_q   <= HANDLE_NONE;
          tail_q   <= HANDLE_NONE;
          count_q  <= '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      DP_LOAD: begin
        act_q         <= action_i;
        val_q         <= item_value_i;
        after_q       <= after_node_i;
        res_status_q  <= ST_OK;
        res_handle_q  <= HANDLE_NONE;
        res_removed_q <= '0;
      end
      DP_PREPEND: begin
        res_handle_q <= slot;
      end
      DP_APPEND: begin
        res_handle_q <= slot;
        cur_q        <= slot;
        prev_q       <= tail_q;
      end
      DP_INS_CLAIM: begin
        res_handle_q <= slot;
        cur_q        <= slot;
      end
      DP_RMH_READ: begin
        cur_q <= head_q;
      end
      DP_RMH_TAKE: begin
        res_removed_q <= val_rd_q;
        res_handle_q  <= cur_q;
      end
      DP_WALK_START: begin
        cur_q  <= head_q;
        prev_q <= HANDLE_NONE;
      end
      DP_WALK_NEXT: begin
        prev_q <= cur_q;
        cur_q  <= link_rd_q;
      end
      DP_FOUND, DP_UNLINK: begin
        res_handle_q <= cur_q;
      end
      DP_SET_MISS: begin
        res_status_q <= ST_MISS;
      end
      DP_SET_FULL: begin
        res_status_q <= ST_FULL;
      end
      DP_SET_STALE: begin
        res_status_q <= ST_STALE;
      end
      DP_EMIT: begin
        out_status_q  <= res_status_q;
        out_handle_q  <= res_handle_q;
        out_removed_q <= res_removed_q;
        out_length_q  <= count_q;
        out_first_q   <= head_q;
        out_last_q    <= tail_q;
      end
      default: begin
      end
    endcase
  end

  assign rsp_valid_o     = out_valid_q;
  assign status_o        = out_status_q;
  assign node_handle_o   = out_handle_q;
  assign removed_value_o = out_removed_q;
  assign list_length_o   = out_length_q;
  assign first_node_o    = out_first_q;
  assign last_node_o     = out_last_q;

endmodule

[rtl/linked_list_manager.sv]
// Top level of the linked list manager: controller plus datapath.
// Depends on llm_pkg, llm_req_if, llm_rsp_if, llm_ctrl and llm_dpath.
//
//   channel  | dir | beat contents
//   ---------+-----+--------------------------------------------------------------
//   req_i    | in  | action, item_value, after_node
//   rsp_o    | out | status, node_handle, removed_value, list_length, first_node,
//            |     | last_node
//
// One request at a time. Each is loaded and dispatched; prepend, clear, the unused
// code and every full, stale or empty-list result then go to the result state;
// append adds a link step, remove head a take step, insert link and after steps;
// find and remove value walk one link per cycle through the registered read port.
// Reset clears in-use bits, head, tail, count and the pending result. A held result
// stalls only the next result; the next request is taken the edge after emit.
module linked_list_manager (
  input logic       clk_i,
  input logic       rst_ni,
  llm_req_if.sink   req_i,
  llm_rsp_if.source rsp_o
);
  import llm_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  llm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  llm_dpath u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .action_i        (req_i.action),
    .item_value_i    (req_i.item_value),
    .after_node_i    (req_i.after_node),
    .rsp_valid_o     (rsp_o.valid),
    .rsp_ready_i     (rsp_o.ready),
    .status_o        (rsp_o.status),
    .node_handle_o   (rsp_o.node_handle),
    .removed_value_o (rsp_o.removed_value),
    .list_length_o   (rsp_o.list_length),
    .first_node_o    (rsp_o.first_node),
    .last_node_o     (rsp_o.last_node)
  );

endmodule

[sim/linked_list_manager_test.sv]
// Self-checking testbench for linked_list_manager: directed list edits, pool exhaustion
// under output back-pressure, then random traffic with gaps on both channels.
// Depends on llm_pkg, llm_req_if, llm_rsp_if and the RTL of linked_list_manager.
`timescale 1ns / 100ps

module linked_list_manager_test;
  import llm_pkg::*;

  localparam int unsigned CLK_PERIOD   = 10;
  localparam int unsigned RANDOM_ITEMS = 800;
  localparam int unsigned STUCK_LIMIT  = 2000;
  localparam int unsigned HOLD_CYCLES  = 150;
  localparam logic [ACT_W-1:0] ACT_RESERVED = 3'd7;

  typedef struct {
    logic [STAT_W-1:0] status;
    handle_t           node;
    value_t            removed;
    handle_t           length;
    handle_t           first;
    handle_t           last;
  } list_reply_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  llm_req_if req_if ();
  llm_rsp_if rsp_if ();

  linked_list_manager i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Predicted list state.
  value_t           node_val[NODES];
  handle_t          node_next[NODES];
  logic [NODES-1:0] node_used;
  handle_t          list_head;
  handle_t          list_tail;
  handle_t          list_size;

  list_reply_t expected_replies[$];
  int unsigned mismatches;
  int unsigned replies_seen;
  int unsigned stuck_cycles;
  bit          req_jitter;
  bit          rsp_jitter;
  int unsigned hold_len;
  int unsigned hold_left;
  int unsigned ready_gap;

  function automatic bit occupied(handle_t h);
    return (h < HANDLE_NONE) && node_used[h[IDX_W-1:0]];
  endfunction

  function automatic list_reply_t apply_action(logic [ACT_W-1:0] act, value_t val, idx_t after);
    list_reply_t r;
    handle_t     slot;
    handle_t     cur;
    handle_t     prev;
    int          steps;
    r.status  = ST_OK;
    r.node    = HANDLE_NONE;
    r.removed = '0;
    case (act)
      ACT_PREPEND, ACT_APPEND, ACT_INSERT: begin
        slot = HANDLE_NONE;
        for (int i = NODES - 1; i >= 0; i--) begin
          if (!node_used[i]) begin
            slot = handle_t'(i);
          end
        end
        if (act == ACT_INSERT && !node_used[after]) begin
          r.status = ST_STALE;
        end else if (slot == HANDLE_NONE) begin
          r.status = ST_FULL;
        end else begin
          node_used[slot[IDX_W-1:0]] = 1'b1;
          node_val[slot[IDX_W-1:0]]  = val;
          if (act == ACT_PREPEND) begin
            node_next[slot[IDX_W-1:0]] = list_head;
            list_head = slot;
            if (list_tail == HANDLE_NONE) begin
              list_tail = slot;
            end
          end else if (act == ACT_APPEND) begin
            node_next[slot[IDX_W-1:0]] = HANDLE_NONE;
            if (occupied(list_tail)) begin
              node_next[list_tail[IDX_W-1:0]] = slot;
            end else begin
              list_head = slot;
            end
            list_tail = slot;
          end else begin
            node_next[slot[IDX_W-1:0]] = node_next[after];
            node_next[after] = slot;
            if (list_tail == handle_t'(after)) begin
              list_tail = slot;
            end
          end
          list_size++;
          r.node = slot;
        end
      end
      ACT_RM_HEAD: begin
        if (!occupied(list_head)) begin
          r.status = ST_MISS;
        end else begin
          cur = list_head;
          r.removed = node_val[cur[IDX_W-1:0]];
          list_head = node_next[cur[IDX_W-1:0]];
          if (list_head == HANDLE_NONE) begin
            list_tail = HANDLE_NONE;
          end
          node_used[cur[IDX_W-1:0]] = 1'b0;
          if (list_size != 0) begin
            list_size--;
          end
          r.node = cur;
        end
      end
      ACT_RM_VAL, ACT_FIND: begin
        prev = HANDLE_NONE;
        cur  = list_head;
        for (steps = 0; steps < NODES && occupied(cur) && node_val[cur[IDX_W-1:0]] != val;
             steps++) begin
          prev = cur;
          cur  = node_next[cur[IDX_W-1:0]];
        end
        if (!occupied(cur) || node_val[cur[IDX_W-1:0]] != val) begin
          r.status = ST_MISS;
        end else begin
          r.node = cur;
          if (act == ACT_RM_VAL) begin
            if (prev == HANDLE_NONE) begin
              list_head = node_next[cur[IDX_W-1:0]];
            end else begin
              node_next[prev[IDX_W-1:0]] = node_next[cur[IDX_W-1:0]];
            end
            if (list_tail == cur) begin
              list_tail = prev;
            end
            node_used[cur[IDX_W-1:0]] = 1'b0;
            if (list_size != 0) begin
              list_size--;
            end
          end
        end
      end
      ACT_CLEAR: begin
        node_used = '0;
        list_head = HANDLE_NONE;
        list_tail = HANDLE_NONE;
        list_size = '0;
      end
      default: begin
      end
    endcase
    r.length = list_size;
    r.first  = list_head;
    r.last   = list_tail;
    return r;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return 0;
    end else if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(10, 40);
  endfunction

  function automatic idx_t pick_node();
    idx_t i;
    do begin
      i = idx_t'($urandom_range(0, NODES - 1));
    end while (!node_used[i]);
    return i;
  endfunction

  function automatic logic [ACT_W-1:0] pick_action(bit grow);
    int unsigned      grow_cut[8]   = '{20, 40, 60, 68, 80, 95, 97, 100};
    int unsigned      shrink_cut[8] = '{8, 16, 24, 49, 74, 94, 97, 100};
    logic [ACT_W-1:0] codes[8]      = '{ACT_PREPEND, ACT_APPEND, ACT_INSERT, ACT_RM_HEAD,
                                        ACT_RM_VAL, ACT_FIND, ACT_CLEAR, ACT_RESERVED};
    int unsigned      r;
    r = $urandom_range(0, 99);
    for (int k = 0; k < 8; k++) begin
      if (r < (grow ? grow_cut[k] : shrink_cut[k])) begin
        return codes[k];
      end
    end
    return ACT_RESERVED;
  endfunction

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("[%0t] beat %0d %s: got %0h, expected %0h", $time, replies_seen, field, got, want);
    mismatches++;
  endtask

  // Drive one request beat from a falling edge; return at a falling edge.
  task automatic issue_action(input logic [ACT_W-1:0] act, input value_t val, input idx_t after);
    int unsigned gap;
    req_if.valid      <= 1'b1;
    req_if.action     <= act;
    req_if.item_value <= val;
    req_if.after_node <= after;
    do @(posedge clk_i); while (!req_if.ready);
    expected_replies.push_back(apply_action(act, val, after));
    @(negedge clk_i);
    gap = req_jitter ? pick_gap() : 0;
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
  endtask

  task automatic test_empty_list();
    issue_action(ACT_FIND, 32'h0000_0000, 4'd0);
    issue_action(ACT_RM_HEAD, 32'h0000_0000, 4'd0);
    issue_action(ACT_RM_VAL, 32'hffff_ffff, 4'd0);
    issue_action(ACT_INSERT, 32'h1234_5678, 4'd0);
    issue_action(ACT_RESERVED, 32'hffff_ffff, 4'd15);
    issue_action(ACT_CLEAR, 32'h0000_0000, 4'd0);
  endtask

  task automatic test_list_edits();
    issue_action(ACT_PREPEND, 32'h0000_0000, 4'd0);
    issue_action(ACT_APPEND, 32'hffff_ffff, 4'd0);
    issue_action(ACT_INSERT, 32'h5a5a_a5a5, 4'd0);
    issue_action(ACT_INSERT, 32'h8000_0001, 4'd1);
    issue_action(ACT_FIND, 32'h5a5a_a5a5, 4'd0);
    issue_action(ACT_FIND, 32'h1234_5678, 4'd0);
    issue_action(ACT_RM_VAL, 32'hffff_ffff, 4'd0);
    issue_action(ACT_RM_VAL, 32'h8000_0001, 4'd0);
    issue_action(ACT_RM_VAL, 32'h0000_0000, 4'd0);
    issue_action(ACT_RM_HEAD, 32'h0000_0000, 4'd0);
    issue_action(ACT_INSERT, 32'h0000_0001, 4'd2);
    issue_action(ACT_APPEND, 32'h0000_0007, 4'd0);
    issue_action(ACT_APPEND, 32'h0000_0007, 4'd0);
    issue_action(ACT_FIND, 32'h0000_0007, 4'd0);
    issue_action(ACT_CLEAR, 32'h0000_0000, 4'd0);
  endtask

  // Fill the pool starting with the response side parked, then walk the full list.
  task automatic test_pool_exhaustion();
    req_jitter = 1'b0;
    rsp_jitter = 1'b0;
    hold_len   = HOLD_CYCLES;
    for (int i = 0; i <= NODES; i++) begin
      issue_action(ACT_APPEND, 32'h1000_0000 + i, 4'd0);
    end
    issue_action(ACT_PREPEND, 32'hcafe_0001, 4'd0);
    issue_action(ACT_INSERT, 32'hcafe_0002, 4'd5);
    issue_action(ACT_FIND, 32'h1000_000f, 4'd0);
    issue_action(ACT_FIND, 32'hdead_beef, 4'd0);
    issue_action(ACT_RM_VAL, 32'h1000_000f, 4'd0);
    issue_action(ACT_INSERT, 32'hcafe_0003, 4'd15);
    issue_action(ACT_RM_HEAD, 32'h0000_0000, 4'd0);
    issue_action(ACT_INSERT, 32'hcafe_0004, 4'd14);
    issue_action(ACT_CLEAR, 32'h0000_0000, 4'd0);
  endtask

  task automatic test_random_traffic();
    value_t           hot_vals[6];
    logic [ACT_W-1:0] act;
    value_t           val;
    idx_t             after;
    int unsigned      sel;
    hot_vals[0] = '0;
    hot_vals[1] = '1;
    for (int k = 2; k < 6; k++) begin
      hot_vals[k] = $urandom;
    end
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 100 == 0) begin
        sel = (n / 100) % 4;
        req_jitter = (sel != 1) && (sel != 3);
        rsp_jitter = (sel != 2) && (sel != 3);
      end
      act = pick_action(((n / 40) % 2) == 0);
      if ((act == ACT_RM_VAL || act == ACT_FIND) && node_used != '0
          && $urandom_range(0, 9) < 7) begin
        val = node_val[pick_node()];
      end else if ($urandom_range(0, 99) < 15) begin
        val = $urandom;
      end else begin
        val = hot_vals[$urandom_range(0, 5)];
      end
      if (node_used != '0 && $urandom_range(0, 9) < 8) begin
        after = pick_node();
      end else begin
        after = idx_t'($urandom_range(0, NODES - 1));
      end
      issue_action(act, val, after);
    end
  endtask

  always @(negedge clk_i) begin
    if (hold_len > 0) begin
      hold_left = hold_len;
      hold_len  = 0;
    end
    if (hold_left > 0) begin
      rsp_if.ready <= 1'b0;
      hold_left--;
    end else if (ready_gap > 0) begin
      rsp_if.ready <= 1'b0;
      ready_gap--;
    end else if (rsp_jitter && $urandom_range(0, 3) == 0) begin
      rsp_if.ready <= 1'b0;
      ready_gap = pick_gap();
    end else begin
      rsp_if.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    list_reply_t want;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (expected_replies.size() == 0) begin
        report_mismatch("unexpected beat, status", 32'(rsp_if.status), '0);
      end else begin
        want = expected_replies.pop_front();
        if (rsp_if.status !== want.status) begin
          report_mismatch("status", 32'(rsp_if.status), 32'(want.status));
        end
        if (rsp_if.node_handle !== want.node) begin
          report_mismatch("node_handle", 32'(rsp_if.node_handle), 32'(want.node));
        end
        if (rsp_if.removed_value !== want.removed) begin
          report_mismatch("removed_value", rsp_if.removed_value, want.removed);
        end
        if (rsp_if.list_length !== want.length) begin
          report_mismatch("list_length", 32'(rsp_if.list_length), 32'(want.length));
        end
        if (rsp_if.first_node !== want.first) begin
          report_mismatch("first_node", 32'(rsp_if.first_node), 32'(want.first));
        end
        if (rsp_if.last_node !== want.last) begin
          report_mismatch("last_node", 32'(rsp_if.last_node), 32'(want.last));
        end
      end
      replies_seen++;
    end
  end

  always @(posedge clk_i) begin
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      stuck_cycles = 0;
    end else begin
      stuck_cycles++;
    end
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    rst_ni            = 1'b0;
    req_if.valid      = 1'b0;
    req_if.action     = ACT_PREPEND;
    req_if.item_value = '0;
    req_if.after_node = '0;
    rsp_if.ready      = 1'b0;
    node_val          = '{default: '0};
    node_next         = '{default: '0};
    node_used         = '0;
    list_head         = HANDLE_NONE;
    list_tail         = HANDLE_NONE;
    list_size         = '0;
    mismatches        = 0;
    replies_seen      = 0;
    stuck_cycles      = 0;
    hold_len          = 0;
    hold_left         = 0;
    ready_gap         = 0;
    req_jitter        = 1'b1;
    rsp_jitter        = 1'b1;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_empty_list();
    test_list_edits();
    test_pool_exhaustion();
    test_random_traffic();

    req_if.valid <= 1'b0;
    rsp_jitter = 1'b0;
    wait (expected_replies.size() == 0);
    repeat (NODES + 8) @(posedge clk_i);
    if (expected_replies.size() != 0) begin
      report_mismatch("missing beats", expected_replies.size(), 0);
    end
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/llm_pkg.sv
rtl/llm_req_if.sv
rtl/llm_rsp_if.sv
rtl/llm_ctrl.sv
rtl/llm_dpath.sv
rtl/linked_list_manager.sv
sim/linked_list_manager_test.sv
